[rtl/wbcs_pkg.sv]
// Package for the white blob column steering block.
// Holds result codes, register indexes, fixed widths and shared types; no dependencies.
package wbcs_pkg;

   localparam int SUM_W  = 34;
   localparam int STEP_W = 6;

   localparam logic [1:0] DIR_STOP    = 2'd0;
   localparam logic [1:0] DIR_LEFT    = 2'd1;
   localparam logic [1:0] DIR_RIGHT   = 2'd2;
   localparam logic [1:0] DIR_FORWARD = 2'd3;

   localparam logic CSR_FRAME_WIDTH = 1'b0;
   localparam logic CSR_WHITE_LEVEL = 1'b1;

   localparam logic [12:0] FRAME_WIDTH_RESET = 13'd640;
   localparam logic [7:0]  WHITE_LEVEL_RESET = 8'd255;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_OUT
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[rtl/white_blob_column_steering.sv]
// White blob column steering top level: front end, frame record queue and back end.
// Depends on wbcs_pkg, wbcs_front, wbcs_queue and wbcs_back.
//
// Pixels are accepted one per clock, in raster order, with no stall while the frame record
// queue has room. Each pixel whose three channels equal white_level adds its column to a
// saturating sum and count. On the frame_end pixel the frame's sum, count and width go into
// a two-entry queue, and the back end turns them into one result: it pops the record, runs a
// one-bit-per-cycle restoring divider for the mean column and then loads the result register
// (a frame without white pixels skips the divider). req_stall rises only when two finished
// frames are still waiting on the back end, which needs frames shorter than the back end's
// work on a frame, or a stalled result channel. Register writes are taken every cycle and
// must happen while no frame is in flight.
module white_blob_column_steering
   import wbcs_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_PIXELS = 4194304
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_direction,
   output logic [11:0] rsp_mean_column,
   output logic [22:0] rsp_white_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CNT_W = $clog2(MAX_PIXELS + 1);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int REC_W = WW + CNT_W + SUM_W;

   queue_status_type q_status;
   logic             push;
   logic [REC_W-1:0] push_data;
   logic             pop;
   logic [REC_W-1:0] pop_data;

   wbcs_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_PIXELS (MAX_PIXELS),
      .COL_W      (COL_W),
      .CNT_W      (CNT_W),
      .WW         (WW),
      .REC_W      (REC_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .req_frame_end (req_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_status      (q_status),
      .push          (push),
      .push_data     (push_data)
   );

   wbcs_queue #(
      .DATA_W (REC_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   wbcs_back #(
      .CNT_W (CNT_W),
      .WW    (WW),
      .REC_W (REC_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .pop_data        (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_direction   (rsp_direction),
      .rsp_mean_column (rsp_mean_column),
      .rsp_white_total (rsp_white_total)
   );

endmodule

[rtl/wbcs_front.sv]
// Front end: configuration registers, column counter and white pixel accumulators.
// Pushes one frame record per frame end into the queue; uses wbcs_pkg.
module wbcs_front
   import wbcs_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_PIXELS = 4194304,
   parameter int COL_W      = 12,
   parameter int CNT_W      = 23,
   parameter int WW         = 13,
   parameter int REC_W      = WW + CNT_W + SUM_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_red,
   input  logic [7:0]       req_green,
   input  logic [7:0]       req_blue,
   input  logic             req_frame_end,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [12:0]      csr_wdata,
   input  queue_status_type q_status,
   output logic             push,
   output logic [REC_W-1:0] push_data
);

   logic [12:0]      frame_width_ff;
   logic [7:0]       white_level_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [WW-1:0]    eff_width;
   logic [SUM_W:0]   sum_add;
   logic             is_white;
   logic             take;
   logic             accept;

   assign csr_ready = 1'b1;
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (frame_width_ff == 13'd0) begin
         eff_width = WW'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = WW'(frame_width_ff);
      end
   end

   always_comb begin
      is_white = (req_red == white_level_ff) && (req_green == white_level_ff) &&
                 (req_blue == white_level_ff);
      take     = is_white && (32'(count_ff) < MAX_PIXELS);
      sum_add  = {1'b0, sum_ff} + (SUM_W+1)'(col_ff);
      if (take) begin
         sum_in   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
         count_in = count_ff + CNT_W'(1);
      end else begin
         sum_in   = sum_ff;
         count_in = count_ff;
      end
      if ((32'(col_ff) + 32'd1) >= 32'(eff_width)) begin
         col_in = '0;
      end else begin
         col_in = col_ff + COL_W'(1);
      end
   end

   assign push      = accept && req_frame_end;
   assign push_data = {eff_width, count_in, sum_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= FRAME_WIDTH_RESET;
         white_level_ff <= WHITE_LEVEL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH: frame_width_ff <= csr_wdata;
            CSR_WHITE_LEVEL: white_level_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (accept) begin
         if (req_frame_end) begin
            col_ff   <= '0;
            sum_ff   <= '0;
            count_ff <= '0;
         end else begin
            col_ff   <= col_in;
            sum_ff   <= sum_in;
            count_ff <= count_in;
         end
      end
   end

endmodule

[rtl/wbcs_queue.sv]
// Two-entry queue of frame records between front and back end.
// Uses wbcs_pkg for the status struct.
module wbcs_queue
   import wbcs_pkg::*;
#(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output queue_status_type  status
);

   logic [DATA_W-1:0] mem_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        fill_ff;

   assign status.full  = (fill_ff == 2'd2);
   assign status.empty = (fill_ff == 2'd0);
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + 2'd1;
            2'b01:   fill_ff <= fill_ff - 2'd1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

[rtl/wbcs_back.sv]
// Back end: bit-serial mean column divider, left/center/right/stop decision and result register.
// Pops frame records from wbcs_queue; uses wbcs_pkg.
module wbcs_back
   import wbcs_pkg::*;
#(
   parameter int CNT_W = 23,
   parameter int WW    = 13,
   parameter int REC_W = WW + CNT_W + SUM_W
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  logic [REC_W-1:0] pop_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_direction,
   output logic [11:0]      rsp_mean_column,
   output logic [22:0]      rsp_white_total
);

   localparam int CW = SUM_W + 3;

   back_state_type    state_ff, state_in;
   logic [SUM_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  div_ff;
   logic [WW-1:0]     width_ff;
   logic [STEP_W-1:0] step_ff;
   logic              rsp_valid_ff;
   logic [1:0]        dir_ff;
   logic [11:0]       mean_ff;
   logic [22:0]       total_ff;

   logic [CNT_W-1:0]  rec_count;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;
   logic [CNT_W-1:0]  rem_step;
   logic [SUM_W-1:0]  quo_step;
   logic [SUM_W+1:0]  m3;
   logic              is_left;
   logic              is_right;
   logic [1:0]        dir_in;
   logic [11:0]       mean_in;
   logic [CNT_W+22:0] total_ext;
   logic              out_free;
   logic              do_step;
   logic              load_out;

   assign rec_count = pop_data[SUM_W +: CNT_W];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      trial    = {rem_ff, quo_ff[SUM_W-1]};
      fits     = trial >= {1'b0, div_ff};
      diff     = trial - {1'b0, div_ff};
      rem_step = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_step = {quo_ff[SUM_W-2:0], fits};
   end

   always_comb begin
      m3       = {2'b00, quo_ff} + {1'b0, quo_ff, 1'b0};
      is_left  = CW'(m3) <= CW'(width_ff);
      is_right = CW'({width_ff, 1'b0}) <= (CW'(m3) + CW'(2));
      if (div_ff == '0) begin
         dir_in  = DIR_STOP;
         mean_in = 12'd0;
      end else begin
         mean_in = quo_ff[11:0];
         if (is_left) begin
            dir_in = DIR_LEFT;
         end else if (is_right) begin
            dir_in = DIR_RIGHT;
         end else begin
            dir_in = DIR_FORWARD;
         end
      end
      total_ext = {23'd0, div_ff};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               state_in = (rec_count == '0) ? BK_OUT : BK_DIV;
            end
         end
         BK_DIV: begin
            if (step_ff == STEP_W'(1)) begin
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      do_step  = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         BK_IDLE: pop      = !q_status.empty;
         BK_DIV:  do_step  = 1'b1;
         BK_OUT:  load_out = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         quo_ff   <= pop_data[SUM_W-1:0];
         rem_ff   <= '0;
         div_ff   <= rec_count;
         width_ff <= pop_data[SUM_W+CNT_W +: WW];
         step_ff  <= STEP_W'(SUM_W);
      end else if (do_step) begin
         quo_ff  <= quo_step;
         rem_ff  <= rem_step;
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         dir_ff   <= dir_in;
         mean_ff  <= mean_in;
         total_ff <= total_ext[22:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_direction   = dir_ff;
   assign rsp_mean_column = mean_ff;
   assign rsp_white_total = total_ff;

endmodule

[rtl/wbcs_checker.sv]
// Port-level checker for white_blob_column_steering, attached by the bind below.
// Uses wbcs_pkg for the direction codes.
module wbcs_checker
   import wbcs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_direction,
   input logic [11:0] rsp_mean_column,
   input logic [22:0] rsp_white_total
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_direction) &&
         $stable(rsp_mean_column) && $stable(rsp_white_total))
      else $error("result changed while stalled");

   a_stop_iff_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_direction == DIR_STOP) == (rsp_white_total == 23'd0)))
      else $error("stop does not match an empty frame");

   a_stop_mean_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_direction == DIR_STOP) |-> (rsp_mean_column == 12'd0))
      else $error("stop result with nonzero mean column");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind white_blob_column_steering wbcs_checker u_wbcs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_direction   (rsp_direction),
   .rsp_mean_column (rsp_mean_column),
   .rsp_white_total (rsp_white_total)
);

[test/white_blob_column_steering_checker.sv]
// Scoreboard for white_blob_column_steering: watches the pixel, result and register channels,
// predicts each frame result and compares it field by field with what the block returns.
// Depends on wbcs_pkg for result codes, register indexes and reset values.
module white_blob_column_steering_checker
   import wbcs_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_PIXELS = 4194304
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_frame_end,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_direction,
   input  logic [11:0] rsp_mean_column,
   input  logic [22:0] rsp_white_total,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata,
   output int          errors,
   output int          frames_pending,
   output int          frames_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  direction;
      logic [11:0] mean_column;
      logic [22:0] white_total;
   } steering_result_type;

   localparam logic [33:0] SUM_LIMIT = '1;

   logic [12:0]         width_reg;
   logic [7:0]          level_reg;
   logic [11:0]         column;
   logic [33:0]         column_sum;
   logic [22:0]         white_count;
   steering_result_type expected_steering[$];

   task automatic flag_mismatch(input string msg);
      $display("%0t ns checker: frame %0d: %s", $realtime, frames_checked, msg);
      errors++;
   endtask

   function automatic int unsigned row_width();
      if (width_reg == 0)
         return 1;
      if (width_reg > MAX_WIDTH)
         return MAX_WIDTH;
      return 32'(width_reg);
   endfunction

   task automatic accumulate_pixel(input logic [7:0] r, g, b, input logic last);
      int unsigned         w;
      logic [34:0]         grown;
      longint unsigned     mean;
      steering_result_type res;
      w = row_width();
      if (r == level_reg && g == level_reg && b == level_reg && white_count < MAX_PIXELS) begin
         grown = {1'b0, column_sum} + 35'(column);
         column_sum = (grown > SUM_LIMIT) ? SUM_LIMIT : grown[33:0];
         white_count++;
      end
      if (int'(column) + 1 >= w)
         column = '0;
      else
         column = column + 1'b1;
      if (last) begin
         res.direction = DIR_STOP;
         res.mean_column = '0;
         res.white_total = white_count;
         if (white_count != 0) begin
            mean = column_sum / white_count;
            res.mean_column = mean[11:0];
            if (mean <= w / 3)
               res.direction = DIR_LEFT;
            else if (mean >= (2 * w) / 3)
               res.direction = DIR_RIGHT;
            else
               res.direction = DIR_FORWARD;
         end
         expected_steering.push_back(res);
         column = '0;
         column_sum = '0;
         white_count = '0;
      end
   endtask

   always @(posedge clock) begin
      steering_result_type want;
      if (reset) begin
         width_reg = FRAME_WIDTH_RESET;
         level_reg = WHITE_LEVEL_RESET;
         column = '0;
         column_sum = '0;
         white_count = '0;
         expected_steering.delete();
         errors = 0;
         frames_checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_steering.size() == 0) begin
               flag_mismatch($sformatf("unexpected result direction %0d mean %0d total %0d",
                  rsp_direction, rsp_mean_column, rsp_white_total));
            end else begin
               want = expected_steering.pop_front();
               if (rsp_direction !== want.direction)
                  flag_mismatch($sformatf("direction got %0d expected %0d",
                     rsp_direction, want.direction));
               if (rsp_mean_column !== want.mean_column)
                  flag_mismatch($sformatf("mean_column got %0d expected %0d",
                     rsp_mean_column, want.mean_column));
               if (rsp_white_total !== want.white_total)
                  flag_mismatch($sformatf("white_total got %0d expected %0d",
                     rsp_white_total, want.white_total));
               frames_checked++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH: width_reg = csr_wdata;
               CSR_WHITE_LEVEL: level_reg = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            accumulate_pixel(req_red, req_green, req_blue, req_frame_end);
      end
      frames_pending = expected_steering.size();
   end

endmodule

[test/tb_white_blob_column_steering.sv]
// Top of the white_blob_column_steering testbench: clock, reset, pixel and register stimulus,
// result back-pressure, watchdog and verdict. Depends on wbcs_pkg, the block and
// white_blob_column_steering_checker, which does all prediction and comparison.
module tb_white_blob_column_steering
   import wbcs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PIXELS = 1600;
   localparam int DRAIN_CYCLES  = 48;
   localparam int QUIET_LIMIT   = 4000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic        req_frame_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_direction;
   logic [11:0] rsp_mean_column;
   logic [22:0] rsp_white_total;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_FRAME_WIDTH;
   logic [12:0] csr_wdata = '0;
   int          errors;
   int          frames_pending;
   int          frames_checked;

   bit          no_idle = 1'b0;
   logic [7:0]  stim_level = WHITE_LEVEL_RESET;
   int          pixels_sent = 0;
   int          config_writes = 0;
   int          quiet_cycles = 0;

   white_blob_column_steering uut (.*);

   white_blob_column_steering_checker scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d frames outstanding",
            QUIET_LIMIT, frames_pending);
         $display("tb_white_blob_column_steering: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result back-pressure: runs of free and stalled cycles, mostly short stalls
   initial begin
      int run;
      bit hold;
      run = 0;
      hold = 1'b0;
      forever begin
         @(posedge clock);
         if (run == 0) begin
            hold = !no_idle && ($urandom_range(0, 9) < 4);
            if (!hold)
               run = $urandom_range(1, 30);
            else if ($urandom_range(0, 9) < 8)
               run = $urandom_range(1, 3);
            else
               run = $urandom_range(15, 60);
         end
         rsp_stall <= hold;
         run--;
      end
   end

   function automatic int idle_gap();
      int pick;
      if (no_idle)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_pixel(input logic [7:0] r, g, b, input logic last);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      req_frame_end <= last;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   // hold off until every frame result is back and the divider has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [12:0] width_data, level_data);
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= width_data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_WHITE_LEVEL;
      csr_wdata <= level_data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      stim_level = level_data[7:0];
      config_writes += 2;
   endtask

   task automatic send_random_pixel(input bit white, input logic last);
      logic [7:0] r, g, b;
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      if (white) begin
         r = stim_level;
         g = stim_level;
         b = stim_level;
      end else begin
         case ($urandom_range(0, 5))
            0: begin r = stim_level; g = stim_level; end
            1: begin r = stim_level; b = stim_level; end
            2: begin g = stim_level; b = stim_level; end
            default: ;
         endcase
      end
      send_pixel(r, g, b, last);
   endtask

   task automatic send_frame(input int len, cols, lo, hi, hit_in, hit_out);
      int  col;
      bit  in_blob;
      for (int i = 0; i < len; i++) begin
         col = i % cols;
         in_blob = (col >= lo) && (col <= hi);
         send_random_pixel($urandom_range(0, 99) < (in_blob ? hit_in : hit_out), i == len - 1);
      end
   endtask

   initial begin
      int          pick;
      int          cols;
      int          len;
      int          budget;
      int          frames;
      int          span;
      int          lo;
      int          hi;
      int          hit_in;
      int          hit_out;
      int          random_start;
      logic [12:0] width_data;
      logic [12:0] level_data;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: single white pixel, then a near miss with nothing white
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_pixel(8'hFF, 8'hFF, 8'hFE, 1'b1);
      settle();

      // level zero from a write with junk upper bits; mean lands in the middle third
      write_config(13'd6, 13'h1F00);
      send_pixel(8'h00, 8'h00, 8'h01, 1'b0);
      send_pixel(8'h01, 8'h00, 8'h00, 1'b0);
      send_pixel(8'h00, 8'h01, 8'h00, 1'b0);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'h07, 8'h07, 8'h07, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      settle();

      // shrink the row mid-frame while the column is past the new width
      send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      settle();
      write_config(13'd3, 13'h0000);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
      settle();

      // width zero acts as one column
      write_config(13'd0, 13'h00AB);
      send_pixel(8'hAB, 8'hAB, 8'hAB, 1'b0);
      send_pixel(8'hAB, 8'hAB, 8'hAB, 1'b0);
      send_pixel(8'hAB, 8'hAB, 8'h00, 1'b1);
      settle();

      // widest register value clamps to the largest row
      write_config(13'h1FFF, 13'h1FFF);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

      random_start = pixels_sent;
      while (pixels_sent < random_start + RANDOM_PIXELS) begin
         settle();
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            case ($urandom_range(0, 3))
               0: width_data = 13'd0;
               1: width_data = 13'd4096;
               2: width_data = 13'h1FFF;
               default: width_data = 13'($urandom_range(3000, 8191));
            endcase
         end else if (pick <= 3) begin
            width_data = 13'($urandom_range(17, 200));
         end else begin
            width_data = 13'($urandom_range(1, 16));
         end
         cols = (width_data == 0) ? 1 : ((width_data > 4096) ? 4096 : int'(width_data));
         level_data = 13'($urandom);
         case ($urandom_range(0, 7))
            0, 1: level_data[7:0] = 8'hFF;
            2: level_data[7:0] = 8'h00;
            default: ;
         endcase
         write_config(width_data, level_data);
         no_idle = ($urandom_range(0, 4) == 0);
         frames = (cols > 200) ? 1 : $urandom_range(1, 6);
         repeat (frames) begin
            budget = random_start + RANDOM_PIXELS - pixels_sent;
            if (cols > 200)
               len = $urandom_range(1300, 1500);
            else if (cols > 16)
               len = $urandom_range(1, 2 * cols);
            else if ($urandom_range(0, 3) != 0)
               len = cols * $urandom_range(1, 6);
            else
               len = $urandom_range(1, 3 * cols + 2);
            if (len > budget)
               len = budget;
            if (len > 0) begin
               span = (len < cols) ? len : cols;
               lo = $urandom_range(0, span - 1);
               hi = $urandom_range(lo, span - 1);
               hit_in = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(30, 100);
               hit_out = (hit_in == 0 || cols > 200) ? 0 : $urandom_range(0, 10);
               send_frame(len, cols, lo, hi, hit_in, hit_out);
            end
         end
      end
      no_idle = 1'b0;
      settle();

      $display("Run covered %0d pixels and %0d checked frame results,", pixels_sent,
         frames_checked);
      $display("with %0d register writes over row widths 0 to 8191 and random white levels.",
         config_writes);
      if (errors == 0) begin
         $display("tb_white_blob_column_steering: PASS");
      end else begin
         $display("tb_white_blob_column_steering: FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/wbcs_pkg.sv
rtl/wbcs_front.sv
rtl/wbcs_queue.sv
rtl/wbcs_back.sv
rtl/white_blob_column_steering.sv
rtl/wbcs_checker.sv
test/white_blob_column_steering_checker.sv
test/tb_white_blob_column_steering.sv
